// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types, operation codes and widths for the fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_INT2FIX = 4'd14,
        OP_FIX2INT = 4'd15
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic                     divide_by_zero;
    } fpa_out_t;

    // side information carried down the pipe beside the arithmetic units
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] simple_value;
        logic                     compare_true;
        logic                     divide_by_zero;
    } fpa_side_t;

endpackage

// File: rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// pipelined signed multiply, 16x16 partial products, shifted and wrapped
// ----------------------------------------------------------------------------
module fpa_mul #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic signed [fpa_pkg::DATA_W-1:0] a,
    input  logic signed [fpa_pkg::DATA_W-1:0] b,
    output logic signed [fpa_pkg::DATA_W-1:0] product
);
    import fpa_pkg::*;

    localparam int PW = 2 * DATA_W;

    // stage 1: split into sign-magnitude halves
    logic [DATA_W-1:0] mag_a_reg, mag_b_reg;
    logic              neg_reg;
    // stage 2: four 16x16 partial products
    logic [DATA_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic              neg2_reg;
    // stage 3: sum
    logic [PW-1:0]     sum_reg;
    logic              neg3_reg;
    // stage 4: signed, shifted
    logic [DATA_W-1:0] out_reg;

    logic [PW-1:0]        sum_next;
    logic signed [PW-1:0] signed_prod;

    always_ff @(posedge clk)
    begin
        mag_a_reg <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        mag_b_reg <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        neg_reg   <= a[DATA_W-1] ^ b[DATA_W-1];

        pp_ll_reg <= mag_a_reg[15:0]  * mag_b_reg[15:0];
        pp_lh_reg <= mag_a_reg[15:0]  * mag_b_reg[31:16];
        pp_hl_reg <= mag_a_reg[31:16] * mag_b_reg[15:0];
        pp_hh_reg <= mag_a_reg[31:16] * mag_b_reg[31:16];
        neg2_reg  <= neg_reg;

        sum_reg   <= sum_next;
        neg3_reg  <= neg2_reg;

        out_reg   <= DATA_W'(signed_prod >>> FRAC_BITS);
    end

    always_comb
    begin
        sum_next = PW'(pp_ll_reg) + (PW'(pp_lh_reg) << 16) + (PW'(pp_hl_reg) << 16)
                 + (PW'(pp_hh_reg) << 32);
        signed_prod = neg3_reg ? (~sum_reg + PW'(1)) : sum_reg;
    end

    // arithmetic shift on an unsigned vector: force signed view
    assign product = out_reg;

endmodule

// File: rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, four quotient bits per stage
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic signed [fpa_pkg::DATA_W-1:0] a,
    input  logic signed [fpa_pkg::DATA_W-1:0] b,
    output logic signed [fpa_pkg::DATA_W-1:0] quotient
);
    import fpa_pkg::*;

    // dividend magnitude is DATA_W + FRAC_BITS bits
    localparam int NW   = DATA_W + FRAC_BITS;
    localparam int BPS  = 4;
    localparam int NST  = (NW + BPS - 1) / BPS;
    localparam int QW   = NST * BPS;
    localparam int RW   = DATA_W + 1;

    logic [QW-1:0]     num_reg [NST+1];
    logic [RW-1:0]     rem_reg [NST+1];
    logic [DATA_W-1:0] den_reg [NST+1];
    logic              neg_reg [NST+1];
    logic [DATA_W-1:0] out_reg;

    logic [NW-1:0]     num_mag;
    logic [DATA_W-1:0] den_mag;

    always_comb
    begin
        num_mag = a[DATA_W-1] ? NW'(-(NW'(a) << FRAC_BITS)) : (NW'(a) << FRAC_BITS);
        den_mag = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= QW'(num_mag);
        rem_reg[0] <= '0;
        den_reg[0] <= den_mag;
        neg_reg[0] <= a[DATA_W-1] ^ b[DATA_W-1];
    end

    genvar s;
    generate
        for (s = 0; s < NST; s++)
        begin : g_stage
            logic [QW-1:0] n;
            logic [RW-1:0] r;
            always_comb
            begin
                n = num_reg[s];
                r = rem_reg[s];
                for (int k = 0; k < BPS; k++)
                begin
                    r = {r[RW-2:0], n[QW-1]};
                    n = {n[QW-2:0], 1'b0};
                    if (r >= RW'(den_reg[s]))
                    begin
                        r = r - RW'(den_reg[s]);
                        n[0] = 1'b1;
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                num_reg[s+1] <= n;
                rem_reg[s+1] <= r;
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        out_reg <= neg_reg[NST] ? DATA_W'(-num_reg[NST]) : DATA_W'(num_reg[NST]);
    end

    assign quotient = out_reg;

endmodule

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// q24.8 fixed-point alu with pipelined multiply and divide
// ----------------------------------------------------------------------------
// usage
// - pulse start with an item on item_in; busy is always low, so a transfer
//   happens at every edge where start is high
// - one result per item appears on item_out with done high for one cycle
// - every operation takes the same latency, set by the divider pipeline
// - throughput is one item per cycle; results come out in issue order
// - simple ops (add, compare, min/max, shifts) finish in the first stage
//   and ride a delay line so all paths line up at the output
// - multiply is a four-stage partial-product pipe, divide a restoring
//   divider retiring four quotient bits per stage
// - divide by zero returns 0 with divide_by_zero set
// - reset clears only the valid bits; data registers are not reset
// - the receiver cannot stall, so there is no back-pressure anywhere
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::fpa_in_t  item_in,
    output logic              done,
    output fpa_pkg::fpa_out_t item_out
);
    import fpa_pkg::*;

    localparam int NW      = DATA_W + FRAC_BITS;
    localparam int DIV_LAT = (NW + 3) / 4 + 2;
    localparam int MUL_LAT = 4;
    // side info stage 1 is registered, then delayed to match the divider
    localparam int SIDE_D  = DIV_LAT;

    logic signed [DATA_W-1:0] a, b;
    op_t                      op;
    fpa_side_t                side_next;
    fpa_side_t                side_reg [SIDE_D];
    logic                     valid_reg [SIDE_D];
    logic signed [DATA_W-1:0] mul_q;
    logic signed [DATA_W-1:0] div_q;
    logic signed [DATA_W-1:0] mul_dly_reg [DIV_LAT-MUL_LAT];

    assign a    = item_in.operand_a;
    assign b    = item_in.operand_b;
    assign op   = op_t'(item_in.operation);
    assign busy = 1'b0;

    // first stage: everything that is not multiply or divide, plus the divide-by-zero check
    always_comb
    begin
        side_next                = '0;
        side_next.op             = op;
        unique case (op)
            OP_ADD:     side_next.simple_value = a + b;
            OP_SUB:     side_next.simple_value = a - b;
            OP_GT:      side_next.compare_true = a > b;
            OP_LT:      side_next.compare_true = a < b;
            OP_GE:      side_next.compare_true = a >= b;
            OP_LE:      side_next.compare_true = a <= b;
            OP_EQ:      side_next.compare_true = a == b;
            OP_NE:      side_next.compare_true = a != b;
            OP_MIN:     side_next.simple_value = (a < b) ? a : b;
            OP_MAX:     side_next.simple_value = (a > b) ? a : b;
            OP_INC:     side_next.simple_value = a + DATA_W'(1);
            OP_DEC:     side_next.simple_value = a - DATA_W'(1);
            OP_INT2FIX: side_next.simple_value = a <<< FRAC_BITS;
            OP_FIX2INT: side_next.simple_value = a >>> FRAC_BITS;
            OP_DIV:     side_next.divide_by_zero = (b == '0);
            default:    side_next.simple_value = '0;
        endcase
    end

    // valid bits travel beside the payload and are the only reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_D; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start;
            for (int i = 1; i < SIDE_D; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // payload part of the delay line, no reset
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_D; i++)
            side_reg[i] <= side_reg[i-1];
    end

    fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk     (clk),
        .a       (a),
        .b       (b),
        .product (mul_q)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .a        (a),
        .b        (b),
        .quotient (div_q)
    );

    // line up the multiplier with the longer divider
    always_ff @(posedge clk)
    begin
        mul_dly_reg[0] <= mul_q;
        for (int i = 1; i < DIV_LAT - MUL_LAT; i++)
            mul_dly_reg[i] <= mul_dly_reg[i-1];
    end

    // output select
    always_comb
    begin
        item_out.compare_true   = side_reg[SIDE_D-1].compare_true;
        item_out.divide_by_zero = side_reg[SIDE_D-1].divide_by_zero;
        case (side_reg[SIDE_D-1].op)
            OP_MUL:  item_out.result_value = mul_dly_reg[DIV_LAT-MUL_LAT-1];
            OP_DIV:  item_out.result_value = side_reg[SIDE_D-1].divide_by_zero
                                             ? '0 : div_q;
            default: item_out.result_value = side_reg[SIDE_D-1].simple_value;
        endcase
    end

    assign done = valid_reg[SIDE_D-1];

endmodule

// File: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks on the fixed-point alu
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              done,
    input fpa_pkg::fpa_out_t item_out
);
    import fpa_pkg::*;

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(item_out.compare_true && item_out.divide_by_zero))
        else $error("compare and divide flags together");

    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && item_out.divide_by_zero) |-> item_out.result_value == '0)
        else $error("divide by zero with nonzero result");

    a_cmp_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && item_out.compare_true) |-> item_out.result_value == '0)
        else $error("comparison with nonzero value");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .done     (done),
    .item_out (item_out)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
// every accepted transfer is run through a local model of the alu and its
// result queued; each done strobe is compared field by field against the
// oldest queued result. directed corners first, then random traffic in
// several phases, some of them with idle gaps.
// ----------------------------------------------------------------------------
module tb;

    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int PIPE_DEPTH = FRAC / 4 + 11;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    fpa_in_t  item_in;
    logic     done;
    fpa_out_t item_out;

    fpa_out_t expected_results[$];
    int       error_count;
    int       idle_pct;

    fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item_in  (item_in),
        .done     (done),
        .item_out (item_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // arithmetic model of one alu operation
    function automatic fpa_out_t alu_compute(fpa_in_t it);
        fpa_out_t    r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] wide;
        logic [31:0] ua;
        logic [31:0] ub;
        r = '0;
        a = it.operand_a;
        b = it.operand_b;
        ua = it.operand_a;
        ub = it.operand_b;
        case (op_t'(it.operation))
            OP_ADD: r.result_value = ua + ub;
            OP_SUB: r.result_value = ua - ub;
            OP_MUL:
            begin
                wide = (a * b) >>> FRAC;
                r.result_value = wide[31:0];
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    // 64-bit signed divide truncates toward zero
                    wide = (a <<< FRAC) / b;
                    r.result_value = wide[31:0];
                end
            end
            OP_GT: r.compare_true = a > b;
            OP_LT: r.compare_true = a < b;
            OP_GE: r.compare_true = a >= b;
            OP_LE: r.compare_true = a <= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            // ties pick operand_b
            OP_MIN: r.result_value = (a < b) ? ua : ub;
            OP_MAX: r.result_value = (a > b) ? ua : ub;
            OP_INC: r.result_value = ua + 32'd1;
            OP_DEC: r.result_value = ua - 32'd1;
            OP_INT2FIX: r.result_value = ua << FRAC;
            default:
            begin
                // arithmetic shift rounds toward minus infinity
                wide = a >>> FRAC;
                r.result_value = wide[31:0];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // one transfer; start stays high until the next item or the end of traffic
    task automatic send_item(op_t op, logic [31:0] a, logic [31:0] b);
        fpa_in_t it;
        it.operation = op;
        it.operand_a = a;
        it.operand_b = b;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(alu_compute(it));
    endtask

    // results checker
    always @(posedge clk)
    begin
        fpa_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (item_out.result_value !== want.result_value)
                    report_mismatch("result_value", item_out.result_value,
                                    want.result_value);
                if (item_out.compare_true !== want.compare_true)
                    report_mismatch("compare_true", 32'(item_out.compare_true),
                                    32'(want.compare_true));
                if (item_out.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", 32'(item_out.divide_by_zero),
                                    32'(want.divide_by_zero));
            end
        end
    end

    function automatic logic [31:0] random_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(1023) - 512;
            3: return $urandom_range(3) << 8;
            default: return $urandom;
        endcase
    endfunction

    // corners: every operation on extreme and special operands
    task automatic test_directed();
        logic [31:0] corners[6];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                    32'h0000_0100, 32'hffff_ff00};
        idle_pct = 0;
        for (int op = 0; op < 16; op++)
            send_item(op_t'(op), corners[op % 6], corners[(op + 1) % 6]);
        send_item(OP_DIV, 32'h0000_0500, 32'h0);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MIN, 32'h0000_0123, 32'h0000_0123);
        send_item(OP_MAX, 32'hffff_fedc, 32'hffff_fedc);
        send_item(OP_FIX2INT, 32'hffff_ff01, 32'h0);
        send_item(OP_INT2FIX, 32'h0080_0000, 32'h0);
        send_item(OP_EQ, 32'h0000_1234, 32'h0000_1234);
    endtask

    // random traffic, divide-by-zero and equal operands mixed in
    task automatic test_random(int count, int pct);
        logic [31:0] a;
        logic [31:0] b;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            case ($urandom_range(9))
                0: b = 32'h0;
                1: b = a;
                default: b = random_operand();
            endcase
            send_item(op_t'($urandom_range(15)), a, b);
        end
    endtask

    initial
    begin
        int waited;
        error_count = 0;
        idle_pct = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        item_in = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(180, 0);
        test_random(170, 65);
        test_random(170, 0);
        test_random(170, 31);
        start <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
